@@ hw/rtl/u8d_pkg.sv @@
// Shared types and constants for the UTF-8 stream decoder.
`timescale 1ns / 1ps

package u8d_pkg;

	localparam int unsigned ByteW   = 8;
	localparam int unsigned CpW     = 21;
	localparam int unsigned LenW    = 3;
	localparam int unsigned StatusW = 2;

	// Result status codes.
	localparam logic [StatusW-1:0] ST_MORE    = 2'd0;
	localparam logic [StatusW-1:0] ST_DONE    = 2'd1;
	localparam logic [StatusW-1:0] ST_ILLEGAL = 2'd2;

	// Bounds on the partial value after the first continuation byte.
	localparam logic [CpW-1:0] Min3Partial = 21'h000020;
	localparam logic [CpW-1:0] Min4Partial = 21'h000010;
	localparam logic [CpW-1:0] Max4Partial = 21'h00010F;

	typedef struct packed {
		logic [1:0]      bytes_left;
		logic [CpW-1:0]  partial_value;
		logic [LenW-1:0] seq_length;
	} dec_state_t;

	typedef struct packed {
		logic [StatusW-1:0] status;
		logic [CpW-1:0]     code_point;
		logic [LenW-1:0]    char_len;
	} dec_result_t;

	localparam dec_state_t IdleState = '{bytes_left: 2'd0, partial_value: '0, seq_length: '0};

endpackage

@@ hw/rtl/u8d_step.sv @@
// Per-byte decode logic: next decoder state and the result for one byte.
`timescale 1ns / 1ps

module u8d_step
	import u8d_pkg::*;
(
	input  logic [ByteW-1:0] data_byte,
	input  dec_state_t       cur_state,
	output dec_state_t       nxt_state,
	output dec_result_t      result
);

	logic [CpW-1:0] shifted;
	logic           is_cont;
	logic           overlong3;
	logic           range4;

	assign shifted = {cur_state.partial_value[CpW-7:0], data_byte[5:0]};
	// A zero byte never has the continuation form, so this covers that case too.
	assign is_cont = (data_byte[7:6] == 2'b10);
	assign overlong3 = (cur_state.bytes_left == 2'd2) && (cur_state.seq_length == 3'd3)
		&& (shifted < Min3Partial);
	assign range4 = (cur_state.bytes_left == 2'd3)
		&& ((shifted < Min4Partial) || (shifted > Max4Partial));

	always_comb begin
		nxt_state = IdleState;
		result    = '{status: ST_ILLEGAL, code_point: '0, char_len: '0};
		if (cur_state.bytes_left == 2'd0) begin
			if (data_byte inside {[8'h00:8'h7F]}) begin
				result = '{status: ST_DONE, code_point: CpW'(data_byte), char_len: 3'd1};
			end else if (data_byte inside {[8'hC2:8'hDF]}) begin
				nxt_state = '{bytes_left: 2'd1, partial_value: CpW'(data_byte[4:0]),
					seq_length: 3'd2};
				result.status = ST_MORE;
			end else if (data_byte inside {[8'hE0:8'hEF]}) begin
				nxt_state = '{bytes_left: 2'd2, partial_value: CpW'(data_byte[3:0]),
					seq_length: 3'd3};
				result.status = ST_MORE;
			end else if (data_byte inside {[8'hF0:8'hF7]}) begin
				nxt_state = '{bytes_left: 2'd3, partial_value: CpW'(data_byte[2:0]),
					seq_length: 3'd4};
				result.status = ST_MORE;
			end
		end else if (is_cont && !overlong3 && !range4) begin
			if (cur_state.bytes_left == 2'd1) begin
				result = '{status: ST_DONE, code_point: shifted,
					char_len: cur_state.seq_length};
			end else begin
				nxt_state = '{bytes_left: cur_state.bytes_left - 2'd1,
					partial_value: shifted, seq_length: cur_state.seq_length};
				result.status = ST_MORE;
			end
		end
	end

endmodule

@@ hw/rtl/utf8_stream_decoder_top.sv @@
// Top level of the UTF-8 stream decoder: input register, decode step, result register.
// An accepted byte waits in the input register until the output register can take its result.
// Throughput: one byte per cycle unless the output stalls.
// The decoder state feeds back through the single decode step.
// A stalled output holds its result while one more byte waits in the input register.
// Reset (arst_n low, asynchronous) empties both registers and returns the decoder to idle.
`timescale 1ns / 1ps

module utf8_stream_decoder_top
	import u8d_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [ByteW-1:0]    in_byte,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [StatusW-1:0]  status,
	output logic [CpW-1:0]      code_point,
	output logic [LenW-1:0]     char_len
);

	// Input register stage. It holds one accepted byte until the decode step
	// can hand its result to the output register.
	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;

	// Decoder state, advanced once for every byte that moves to the output.
	dec_state_t  state_q;
	dec_state_t  state_nxt;
	dec_result_t res_nxt;

	// Output register stage.
	logic        out_valid_q;
	dec_result_t res_q;

	// A byte moves from the input register into the output register when the
	// output register is empty or its transaction completes in this cycle.
	logic out_move;

	assign out_move = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || out_move;

	u8d_step u_step (
		.data_byte (byte_s1),
		.cur_state (state_q),
		.nxt_state (state_nxt),
		.result    (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

	// The state only updates when its byte's result is committed, so a
	// stall on the output leaves it untouched.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IdleState;
			out_valid_q <= 1'b0;
		end else begin
			if (out_move) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_move) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = res_q.status;
	assign code_point = res_q.code_point;
	assign char_len   = res_q.char_len;

endmodule

@@ hw/rtl/u8d_checker.sv @@
// Port-level checker for the UTF-8 stream decoder and its bind statement.
`timescale 1ns / 1ps

module u8d_checker
	import u8d_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [StatusW-1:0] status,
	input logic [CpW-1:0]     code_point,
	input logic [LenW-1:0]    char_len
);

	// Only the three defined status codes ever appear.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_MORE || status == ST_DONE || status == ST_ILLEGAL))
		else $error("u8d: undefined status code");

	// Results that do not complete a character carry zero payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_DONE) |-> (code_point == '0 && char_len == '0))
		else $error("u8d: payload not zero on incomplete result");

	// A completed character has one to four bytes, and one-byte characters are ASCII.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_DONE) |->
			(char_len >= 3'd1 && char_len <= 3'd4 && (char_len != 3'd1 || code_point < 21'h80)))
		else $error("u8d: bad length on completed character");

	// A stalled result holds until its transaction completes.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
			(out_valid && $stable(status) && $stable(code_point) && $stable(char_len)))
		else $error("u8d: result changed while stalled");

	// An idle output with an empty pipeline never refuses input.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid && !$past(in_valid && in_ready)) |-> in_ready)
		else $error("u8d: input refused while empty");

endmodule

bind utf8_stream_decoder_top u8d_checker u_u8d_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.status     (status),
	.code_point (code_point),
	.char_len   (char_len)
);

@@ verif/tb.sv @@
// Self-checking testbench for the UTF-8 stream decoder top level.
`timescale 1ns / 1ps

module tb;
	import u8d_pkg::*;

	// The run is short, ~1600 bytes, so this limit only trips if the block hangs or
	// drops a transaction.
	localparam int CycleLimit  = 200000;
	// Long enough for both internal registers to fill and the input to stall.
	localparam int HoldCycles  = 60;
	// Covers the path from the input register to the output, plus some margin.
	localparam int DrainCycles = 6;
	localparam int TotalBytes  = 1600;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	logic [ByteW-1:0]    in_byte   = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [StatusW-1:0]  status;
	logic [CpW-1:0]      code_point;
	logic [LenW-1:0]     char_len;

	utf8_stream_decoder_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.code_point (code_point),
		.char_len   (char_len)
	);

	// 20 ns period: low half, then high half.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Decoder state as the testbench sees it, advanced once per accepted byte.
	dec_state_t  decode_state = IdleState;
	// Results owed by the block, oldest first.
	dec_result_t owed_results [$];

	int error_count   = 0;
	int bytes_sent    = 0;
	int cycle_count   = 0;
	int tx_idle_pct   = 35;
	int rx_idle_pct   = 65;
	bit hold_req      = 1'b0;
	int hold_cnt      = 0;
	int more_count    = 0;
	int illegal_count = 0;
	int done_count [1:4] = '{0, 0, 0, 0};

	// One row of the directed table. When "typed" is set the expected result is
	// written out by hand; otherwise the decode predictor supplies it.
	typedef struct {
		logic [ByteW-1:0]   data;
		bit                 typed;
		logic [StatusW-1:0] st;
		logic [CpW-1:0]     cp;
		logic [LenW-1:0]    len;
	} dir_row_t;

	dir_row_t dir_rows [0:24] = '{
		// ASCII extremes, including the zero byte completing character 0.
		'{8'h00, 1'b1, ST_DONE,    21'h00, 3'd1},
		'{8'h7F, 1'b1, ST_DONE,    21'h7F, 3'd1},
		// Bad lead bytes: a stray continuation byte and a byte above 0xF7.
		'{8'h80, 1'b1, ST_ILLEGAL, 21'h00, 3'd0},
		'{8'hF8, 1'b1, ST_ILLEGAL, 21'h00, 3'd0},
		// Overlong two-byte leads.
		'{8'hC0, 1'b1, ST_ILLEGAL, 21'h00, 3'd0},
		'{8'hC1, 1'b1, ST_ILLEGAL, 21'h00, 3'd0},
		// Smallest legal two-byte character.
		'{8'hC2, 1'b1, ST_MORE,    21'h00, 3'd0},
		'{8'h80, 1'b0, ST_MORE,    21'h00, 3'd0},
		// Overlong three-byte sequence rejected on the first continuation byte.
		'{8'hE0, 1'b1, ST_MORE,    21'h00, 3'd0},
		'{8'h9F, 1'b1, ST_ILLEGAL, 21'h00, 3'd0},
		// A surrogate decodes like any other code point.
		'{8'hED, 1'b1, ST_MORE,    21'h00, 3'd0},
		'{8'hA0, 1'b0, ST_MORE,    21'h00, 3'd0},
		'{8'h80, 1'b0, ST_MORE,    21'h00, 3'd0},
		// Four-byte sequences above and below the legal range.
		'{8'hF4, 1'b1, ST_MORE,    21'h00, 3'd0},
		'{8'h90, 1'b1, ST_ILLEGAL, 21'h00, 3'd0},
		'{8'hF0, 1'b1, ST_MORE,    21'h00, 3'd0},
		'{8'h8F, 1'b1, ST_ILLEGAL, 21'h00, 3'd0},
		// Largest code point.
		'{8'hF4, 1'b1, ST_MORE,    21'h00, 3'd0},
		'{8'h8F, 1'b0, ST_MORE,    21'h00, 3'd0},
		'{8'hBF, 1'b0, ST_MORE,    21'h00, 3'd0},
		'{8'hBF, 1'b0, ST_MORE,    21'h00, 3'd0},
		// A non-continuation byte where one is due is consumed as an error.
		'{8'hE2, 1'b1, ST_MORE,    21'h00, 3'd0},
		'{8'h41, 1'b1, ST_ILLEGAL, 21'h00, 3'd0},
		// So is a zero byte in that place.
		'{8'hC3, 1'b1, ST_MORE,    21'h00, 3'd0},
		'{8'h00, 1'b1, ST_ILLEGAL, 21'h00, 3'd0}
	};

	// Predicts the result of one byte and advances the predicted decoder state.
	function automatic dec_result_t decode_step(input logic [ByteW-1:0] b);
		dec_result_t    r;
		logic [CpW-1:0] acc;
		r = '{status: ST_MORE, code_point: '0, char_len: '0};
		if (decode_state.bytes_left == 2'd0) begin
			if (!b[7]) begin
				r.status     = ST_DONE;
				r.code_point = {{(CpW-ByteW){1'b0}}, b};
				r.char_len   = 3'd1;
			end else if (b[7:5] == 3'b110 && b[4:1] != 4'd0) begin
				decode_state = '{bytes_left: 2'd1, partial_value: {16'd0, b[4:0]},
					seq_length: 3'd2};
			end else if (b[7:4] == 4'b1110) begin
				decode_state = '{bytes_left: 2'd2, partial_value: {17'd0, b[3:0]},
					seq_length: 3'd3};
			end else if (b[7:3] == 5'b11110) begin
				decode_state = '{bytes_left: 2'd3, partial_value: {18'd0, b[2:0]},
					seq_length: 3'd4};
			end else begin
				r.status = ST_ILLEGAL;
			end
			return r;
		end
		// A zero byte also fails this test, so it needs no case of its own.
		if (b[7:6] != 2'b10) begin
			decode_state = IdleState;
			r.status     = ST_ILLEGAL;
			return r;
		end
		acc = {decode_state.partial_value[CpW-7:0], b[5:0]};
		if ((decode_state.bytes_left == 2'd2 && decode_state.seq_length == 3'd3 &&
				acc < Min3Partial) ||
				(decode_state.bytes_left == 2'd3 &&
				(acc < Min4Partial || acc > Max4Partial))) begin
			decode_state = IdleState;
			r.status     = ST_ILLEGAL;
			return r;
		end
		if (decode_state.bytes_left == 2'd1) begin
			r.status     = ST_DONE;
			r.code_point = acc;
			r.char_len   = decode_state.seq_length;
			decode_state = IdleState;
		end else begin
			decode_state.bytes_left    = decode_state.bytes_left - 2'd1;
			decode_state.partial_value = acc;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		error_count++;
	endtask

	// Offers one byte and waits for its transaction. The byte's expected result
	// is queued at the edge where it is accepted. A random gap with valid low
	// may come first; valid is never dropped and raised in the same step.
	task automatic send_byte(input logic [ByteW-1:0] b, input bit typed,
			input dec_result_t typed_res);
		dec_result_t res;
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < tx_idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		res = decode_step(b);
		if (typed)
			res = typed_res;
		owed_results.push_back(res);
		bytes_sent++;
	endtask

	// Sends one character. Most are well formed with a random code point of a
	// random length; the rest are single noise bytes or sequences broken by a
	// bad or missing continuation byte.
	task automatic send_random_char();
		logic [ByteW-1:0] seq [0:3];
		logic [CpW-1:0]   cp;
		int               n;
		int               kind;
		int               pick;
		int               lo [1:4];
		int               hi [1:4];
		lo   = '{'h0, 'h80, 'h800, 'h10000};
		hi   = '{'h7F, 'h7FF, 'hFFFF, 'h10FFFF};
		kind = $urandom_range(0, 99);
		n    = $urandom_range(1, 4);
		case ($urandom_range(0, 9))
			0: cp = CpW'(lo[n]);
			1: cp = CpW'(hi[n]);
			default: cp = CpW'($urandom_range(lo[n], hi[n]));
		endcase
		case (n)
			1: seq[0] = cp[7:0];
			2: begin
				seq[0] = {3'b110, cp[10:6]};
				seq[1] = {2'b10, cp[5:0]};
			end
			3: begin
				seq[0] = {4'b1110, cp[15:12]};
				seq[1] = {2'b10, cp[11:6]};
				seq[2] = {2'b10, cp[5:0]};
			end
			default: begin
				seq[0] = {5'b11110, cp[20:18]};
				seq[1] = {2'b10, cp[17:12]};
				seq[2] = {2'b10, cp[11:6]};
				seq[3] = {2'b10, cp[5:0]};
			end
		endcase
		if (kind < 15) begin
			seq[0] = ByteW'($urandom_range(0, 255));
			n      = 1;
		end else if (kind < 30 && n > 1) begin
			pick = $urandom_range(1, n - 1);
			if ($urandom_range(0, 1) == 0) begin
				// Cut the sequence short so the next lead lands in a continuation slot.
				n = pick;
			end else begin
				seq[pick] = ($urandom_range(0, 3) == 0) ? 8'h00 :
					ByteW'($urandom_range(0, 255));
			end
		end
		for (int i = 0; i < n; i++)
			send_byte(seq[i], 1'b0, '0);
	endtask

	// Drops valid and waits until every owed result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
	endtask

	// Receiver: random stalls at the current rate, or a long hold-off on request,
	// counted down here so the sender can keep offering bytes meanwhile.
	always @(posedge clk) begin
		if (hold_req) begin
			hold_cnt = HoldCycles;
			hold_req = 1'b0;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// Checks each output transaction against the oldest owed result, field by field.
	always @(posedge clk) begin
		dec_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (owed_results.size() == 0) begin
				report_mismatch($sformatf("unexpected transaction: status %0d cp %h len %0d",
					status, code_point, char_len));
			end else begin
				want = owed_results.pop_front();
				if (status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
				if (code_point !== want.code_point)
					report_mismatch($sformatf("code_point %h, expected %h",
						code_point, want.code_point));
				if (char_len !== want.char_len)
					report_mismatch($sformatf("char_len %0d, expected %0d",
						char_len, want.char_len));
				case (want.status)
					ST_DONE:    if (want.char_len >= 3'd1 && want.char_len <= 3'd4)
						done_count[want.char_len]++;
					ST_ILLEGAL: illegal_count++;
					default:    more_count++;
				endcase
			end
		end
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("timeout after %0d cycles, %0d results still owed",
				cycle_count, owed_results.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table first, under the first idling mix.
		foreach (dir_rows[i])
			send_byte(dir_rows[i].data, dir_rows[i].typed,
				'{status: dir_rows[i].st, code_point: dir_rows[i].cp,
				char_len: dir_rows[i].len});

		// Long receiver hold-off while the sender keeps offering, so the block
		// fills and stalls its input; then a full drain before going on.
		hold_req = 1'b1;
		repeat (12)
			send_random_char();
		drain_results();

		// Sender idle 35 percent, receiver idle 65 percent.
		while (bytes_sent < TotalBytes / 3)
			send_random_char();

		// The other way round.
		tx_idle_pct = 65;
		rx_idle_pct = 35;
		while (bytes_sent < 2 * TotalBytes / 3)
			send_random_char();

		// Neither side idles: back-to-back transactions in both directions.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		while (bytes_sent < TotalBytes)
			send_random_char();

		drain_results();
		repeat (DrainCycles) @(posedge clk);

		$display("Sent %0d bytes; %0d partial, %0d illegal-sequence results.",
			bytes_sent, more_count, illegal_count);
		$display("Completed characters by length 1/2/3/4: %0d/%0d/%0d/%0d.",
			done_count[1], done_count[2], done_count[3], done_count[4]);
		if (error_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches", error_count);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
